/* rtl/dnnf_pkg.sv */
package dnnf_pkg;

    localparam int KEY_W   = 32;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 32;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = 33;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INSERT,
        ST_OUT_RD,
        ST_OUT_LAT,
        ST_IN_RD,
        ST_IN_LAT,
        ST_IN_WAIT,
        ST_SQRT,
        ST_EMIT
    } state_t;

endpackage

/* rtl/dnnf_sqdist.sv */
// Squared distance over one shared 32x32 multiplier: diff, dx^2, dy^2, add.
module dnnf_sqdist
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [dnnf_pkg::COORD_W-1:0]  xa,
    input  logic signed [dnnf_pkg::COORD_W-1:0]  ya,
    input  logic signed [dnnf_pkg::COORD_W-1:0]  xb,
    input  logic signed [dnnf_pkg::COORD_W-1:0]  yb,
    output logic                                 done,
    output logic        [dnnf_pkg::SUM_W-1:0]    sum
);

    localparam int DIFF_W = dnnf_pkg::DIFF_W;

    logic [1:0]                      step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic [dnnf_pkg::DIFF_W-1:0]     dx_reg, dy_reg;
    logic [dnnf_pkg::SQ_W-1:0]       px_reg, py_reg;
    logic [dnnf_pkg::SUM_W-1:0]      sum_reg;
    logic                            done_reg;
    logic signed [dnnf_pkg::COORD_W:0] dxs, dys;
    logic [dnnf_pkg::DIFF_W-1:0]     mul_a;
    logic [dnnf_pkg::SQ_W-1:0]       mul_p;

    assign dxs = {xa[dnnf_pkg::COORD_W-1], xa} - {xb[dnnf_pkg::COORD_W-1], xb};
    assign dys = {ya[dnnf_pkg::COORD_W-1], ya} - {yb[dnnf_pkg::COORD_W-1], yb};

    assign mul_a = (step_reg == 2'd1) ? dx_reg : dy_reg;
    assign mul_p = mul_a * mul_a;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = 2'd0;
            end
        end
        else
        begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= busy_reg && (step_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (step_reg)
                2'd0:
                begin
                    dx_reg <= dxs[dnnf_pkg::COORD_W] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
                    dy_reg <= dys[dnnf_pkg::COORD_W] ? DIFF_W'(-dys) : DIFF_W'(dys);
                end
                2'd1:    px_reg <= mul_p;
                2'd2:    py_reg <= mul_p;
                default: sum_reg <= {1'b0, px_reg} + {1'b0, py_reg};
            endcase
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

/* rtl/dnnf_isqrt.sv */
// Restoring integer square root, one result bit per cycle.
module dnnf_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [dnnf_pkg::SUM_W-1:0]        radicand,
    output logic                              done,
    output logic [dnnf_pkg::ROOT_W-1:0]       root
);

    localparam int RAD_W = 2 * dnnf_pkg::ROOT_W;
    localparam int REM_W = dnnf_pkg::ROOT_W + 3;
    localparam int SH_W  = REM_W + 2;
    localparam int CNT_W = $clog2(dnnf_pkg::ROOT_W + 1);

    logic                            busy_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            done_reg;
    logic [RAD_W-1:0]                rad_reg;
    logic [REM_W-1:0]                rem_reg;
    logic [dnnf_pkg::ROOT_W-1:0]     root_reg;
    logic [SH_W-1:0]                 rem_sh, trial;
    logic                            fits;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {3'b000, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(dnnf_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (start)
            begin
                rad_reg  <= {1'b0, radicand};
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        else
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[dnnf_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[dnnf_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/dedup_nearest_neighbour_finder_core.sv */
// Nearest-neighbour finder with duplicate-key removal.
// Slave stream: one point per transaction, tdata = {y, x, key}, tlast ends the set.
// Each point is compared against every stored key, in a read and a compare state;
// a new key is stored, a repeated key dropped, a key past MAX_POINTS sets overflow.
// s_tready is low while a point or a set is being worked on.
// On tlast the block walks all pairs through one shared squared-distance unit
// and one bit-serial square root, run once for each point that has a neighbour.
// Master stream: one transaction per stored point, in load order, tdata =
// {distance, nearest_key, from_key}, tuser = {store_overflow, neighbour_valid},
// tlast on the final result. A single output register holds each result; the next
// point is computed while it waits, and the walk pauses when it is still full.
// Reset empties the store and clears overflow; stored words need no clearing.
module dedup_nearest_neighbour_finder_core
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // place_key[31:0], x_coord[63:32], y_coord[95:64]
    input  logic [dnnf_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // from_key[31:0], nearest_key[63:32], distance[96:64], zero fill above
    output logic [dnnf_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // neighbour_valid[0], store_overflow[1]
    output logic [dnnf_pkg::OUT_TUSER_W-1:0]      m_tuser,
    output logic                                  m_tlast
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = dnnf_pkg::KEY_W;
    localparam int PW = dnnf_pkg::COORD_W;

    logic [KW-1:0] key_mem [MAX_POINTS];
    logic [PW-1:0] x_mem   [MAX_POINTS];
    logic [PW-1:0] y_mem   [MAX_POINTS];

    dnnf_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  count_reg, count_next;
    logic           overflow_reg, overflow_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  jdx_reg, jdx_next;
    logic           dup_reg, dup_next;
    logic           found_reg, found_next;
    logic [KW-1:0]  in_key_reg;
    logic [PW-1:0]  in_x_reg, in_y_reg;
    logic           in_end_reg;
    logic [KW-1:0]  ki_reg;
    logic [PW-1:0]  xi_reg, yi_reg;
    logic [KW-1:0]  best_key_reg;
    logic [dnnf_pkg::SUM_W-1:0] best_sq_reg;

    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic [KW-1:0]  rkey;
    logic [PW-1:0]  rx, ry;
    logic           wr_en;

    logic           sq_start, sq_done;
    logic [dnnf_pkg::SUM_W-1:0] sq_sum;
    logic           rt_start, rt_done;
    logic [dnnf_pkg::ROOT_W-1:0] rt_root;

    logic           load_in, take_i, take_best, emit;
    logic           out_free, last_pt;

    logic           mv_reg;
    logic [KW-1:0]  o_from_reg, o_near_reg;
    logic [dnnf_pkg::ROOT_W-1:0] o_dist_reg;
    logic           o_valid_reg, o_ovf_reg, o_last_reg;

    assign out_free = !mv_reg || m_tready;
    assign last_pt  = (idx_reg + 1'b1) == count_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        idx_next      = idx_reg;
        jdx_next      = jdx_reg;
        dup_next      = dup_reg;
        found_next    = found_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IW-1:0];
        wr_en         = 1'b0;
        sq_start      = 1'b0;
        rt_start      = 1'b0;
        load_in       = 1'b0;
        take_i        = 1'b0;
        take_best     = 1'b0;
        emit          = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            dnnf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    load_in    = 1'b1;
                    idx_next   = '0;
                    dup_next   = 1'b0;
                    state_next = dnnf_pkg::ST_SCAN_RD;
                end
            end
            dnnf_pkg::ST_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                    state_next = dnnf_pkg::ST_INSERT;
                else
                begin
                    rd_en      = 1'b1;
                    state_next = dnnf_pkg::ST_SCAN_CMP;
                end
            end
            dnnf_pkg::ST_SCAN_CMP:
            begin
                if (rkey == in_key_reg)
                    dup_next = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = dnnf_pkg::ST_SCAN_RD;
            end
            dnnf_pkg::ST_INSERT:
            begin
                if (!dup_reg)
                begin
                    if (count_reg < CW'(MAX_POINTS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        overflow_next = 1'b1;
                end
                idx_next   = '0;
                state_next = in_end_reg ? dnnf_pkg::ST_OUT_RD : dnnf_pkg::ST_IDLE;
            end
            dnnf_pkg::ST_OUT_RD:
            begin
                rd_en      = 1'b1;
                state_next = dnnf_pkg::ST_OUT_LAT;
            end
            dnnf_pkg::ST_OUT_LAT:
            begin
                take_i     = 1'b1;
                jdx_next   = '0;
                found_next = 1'b0;
                state_next = dnnf_pkg::ST_IN_RD;
            end
            dnnf_pkg::ST_IN_RD:
            begin
                rd_addr = jdx_reg[IW-1:0];
                if (jdx_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        rt_start   = 1'b1;
                        state_next = dnnf_pkg::ST_SQRT;
                    end
                    else
                        state_next = dnnf_pkg::ST_EMIT;
                end
                else if (jdx_reg == idx_reg)
                    jdx_next = jdx_reg + 1'b1;
                else
                begin
                    rd_en      = 1'b1;
                    state_next = dnnf_pkg::ST_IN_LAT;
                end
            end
            dnnf_pkg::ST_IN_LAT:
            begin
                sq_start   = 1'b1;
                state_next = dnnf_pkg::ST_IN_WAIT;
            end
            dnnf_pkg::ST_IN_WAIT:
            begin
                if (sq_done)
                begin
                    // strict compare keeps the earliest point among equal minima
                    if (!found_reg || (sq_sum < best_sq_reg))
                    begin
                        take_best  = 1'b1;
                        found_next = 1'b1;
                    end
                    jdx_next   = jdx_reg + 1'b1;
                    state_next = dnnf_pkg::ST_IN_RD;
                end
            end
            dnnf_pkg::ST_SQRT:
            begin
                if (rt_done)
                    state_next = dnnf_pkg::ST_EMIT;
            end
            dnnf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (last_pt)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = dnnf_pkg::ST_IDLE;
                    end
                    else
                        state_next = dnnf_pkg::ST_OUT_RD;
                end
            end
            default: state_next = dnnf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dnnf_pkg::ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            jdx_reg      <= '0;
            dup_reg      <= 1'b0;
            found_reg    <= 1'b0;
            mv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            idx_reg      <= idx_next;
            jdx_reg      <= jdx_next;
            dup_reg      <= dup_next;
            found_reg    <= found_next;
            if (emit)
                mv_reg <= 1'b1;
            else if (m_tready)
                mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[count_reg[IW-1:0]] <= in_key_reg;
            x_mem[count_reg[IW-1:0]]   <= in_x_reg;
            y_mem[count_reg[IW-1:0]]   <= in_y_reg;
        end
        if (rd_en)
        begin
            rkey <= key_mem[rd_addr];
            rx   <= x_mem[rd_addr];
            ry   <= y_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_key_reg <= s_tdata[KW-1:0];
            in_x_reg   <= s_tdata[KW+PW-1:KW];
            in_y_reg   <= s_tdata[KW+2*PW-1:KW+PW];
            in_end_reg <= s_tlast;
        end
        if (take_i)
        begin
            ki_reg <= rkey;
            xi_reg <= rx;
            yi_reg <= ry;
        end
        if (take_best)
        begin
            best_key_reg <= rkey;
            best_sq_reg  <= sq_sum;
        end
        if (emit)
        begin
            o_from_reg  <= ki_reg;
            o_near_reg  <= found_reg ? best_key_reg : '0;
            o_dist_reg  <= found_reg ? rt_root : '0;
            o_valid_reg <= found_reg;
            o_ovf_reg   <= overflow_reg;
            o_last_reg  <= last_pt;
        end
    end

    dnnf_sqdist u_sqdist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .xa    (xi_reg),
        .ya    (yi_reg),
        .xb    (rx),
        .yb    (ry),
        .done  (sq_done),
        .sum   (sq_sum)
    );

    dnnf_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (best_sq_reg),
        .done     (rt_done),
        .root     (rt_root)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(dnnf_pkg::OUT_TDATA_W - 2*KW - dnnf_pkg::ROOT_W){1'b0}},
                       o_dist_reg, o_near_reg, o_from_reg};
    assign m_tuser  = {o_ovf_reg, o_valid_reg};
    assign m_tlast  = o_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_pt |=> (count_reg == '0) && !overflow_reg)
        else $error("store not emptied after final result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready while a point is being processed");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!mv_reg || m_tready))
        else $error("result overwritten before transaction");

endmodule

/* bench/dedup_nearest_neighbour_finder_core_tb.sv */
module dedup_nearest_neighbour_finder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = 64;

    typedef struct {
        logic [31:0] key;
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic        drain_first;
    } point_t;

    typedef struct packed {
        logic [31:0] from_key;
        logic [31:0] nearest_key;
        logic [32:0] distance;
        logic        neighbour_valid;
        logic        store_overflow;
        logic        final_result;
    } neighbour_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [dnnf_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [dnnf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [dnnf_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic                             m_tlast;

    point_t     pending_points[$];
    neighbour_t expected_neighbours[$];

    // predictor copy of the point store
    logic [31:0] keys_q[MAX_PTS];
    logic [31:0] xs_q[MAX_PTS];
    logic [31:0] ys_q[MAX_PTS];
    int          stored_cnt;
    logic        ovf_seen;

    int  mismatches;
    int  results_seen;
    int  sets_done;
    int  overflow_sets;
    int  burst_left;
    int  gap_left;
    int  stall_left;
    bit  long_stall_done;
    bit  in_acc;

    dedup_nearest_neighbour_finder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [64:0] dist_sq(int i, int j);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [31:0]        ax;
        logic [31:0]        ay;
        dx = $signed({xs_q[i][31], xs_q[i]}) - $signed({xs_q[j][31], xs_q[j]});
        dy = $signed({ys_q[i][31], ys_q[i]}) - $signed({ys_q[j][31], ys_q[j]});
        ax = dx < 0 ? 32'(-dx) : 32'(dx);
        ay = dy < 0 ? 32'(-dy) : 32'(dy);
        return 65'(64'(ax) * 64'(ax)) + 65'(64'(ay) * 64'(ay));
    endfunction

    function automatic logic [32:0] int_sqrt(logic [64:0] s);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= 68'(s))
                r = c;
        end
        return r[32:0];
    endfunction

    task automatic absorb_point(point_t p);
        bit          dup;
        bit          found;
        int          best;
        logic [64:0] best_sq;
        logic [64:0] s;
        neighbour_t  nb;
        dup = 0;
        for (int i = 0; i < stored_cnt; i++)
            if (keys_q[i] == p.key)
                dup = 1;
        if (!dup)
        begin
            if (stored_cnt < MAX_PTS)
            begin
                keys_q[stored_cnt] = p.key;
                xs_q[stored_cnt]   = p.x;
                ys_q[stored_cnt]   = p.y;
                stored_cnt++;
            end
            else
                ovf_seen = 1'b1;
        end
        if (!p.last)
            return;
        if (ovf_seen)
            overflow_sets++;
        for (int i = 0; i < stored_cnt; i++)
        begin
            found   = 0;
            best    = 0;
            best_sq = '0;
            for (int j = 0; j < stored_cnt; j++)
            begin
                if (j == i)
                    continue;
                s = dist_sq(i, j);
                if (!found || s < best_sq)
                begin
                    found   = 1;
                    best    = j;
                    best_sq = s;
                end
            end
            nb.from_key        = keys_q[i];
            nb.nearest_key     = found ? keys_q[best] : 32'd0;
            nb.distance        = found ? int_sqrt(best_sq) : 33'd0;
            nb.neighbour_valid = found;
            nb.store_overflow  = ovf_seen;
            nb.final_result    = (i + 1 == stored_cnt);
            expected_neighbours.push_back(nb);
        end
        stored_cnt = 0;
        ovf_seen   = 1'b0;
        sets_done++;
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_acc))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_points.size() > 0 &&
                     !(pending_points[0].drain_first && expected_neighbours.size() > 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_points[0].y, pending_points[0].x, pending_points[0].key};
                s_tlast  <= pending_points[0].last;
                void'(pending_points.pop_front());
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern, plus one long hold-off
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!long_stall_done && results_seen >= 40)
        begin
            long_stall_done <= 1;
            stall_left      <= 3000;
            m_tready        <= 1'b0;
        end
        else if (results_seen % 50 < 20)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // monitor: accept inputs into the predictor, check results
    always @(posedge clk)
    begin
        point_t     p;
        neighbour_t exp_nb;
        neighbour_t got;
        in_acc <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            p.key  = s_tdata[31:0];
            p.x    = s_tdata[63:32];
            p.y    = s_tdata[95:64];
            p.last = s_tlast;
            p.drain_first = 0;
            absorb_point(p);
        end
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            got.from_key        = m_tdata[31:0];
            got.nearest_key     = m_tdata[63:32];
            got.distance        = m_tdata[96:64];
            got.neighbour_valid = m_tuser[0];
            got.store_overflow  = m_tuser[1];
            got.final_result    = m_tlast;
            if (expected_neighbours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: from %h nearest %h dist %h",
                             got.from_key, got.nearest_key, got.distance);
            end
            else
            begin
                exp_nb = expected_neighbours.pop_front();
                if (got != exp_nb)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp from %h near %h dist %h v%b o%b l%b",
                                  " / got from %h near %h dist %h v%b o%b l%b"},
                                 exp_nb.from_key, exp_nb.nearest_key, exp_nb.distance,
                                 exp_nb.neighbour_valid, exp_nb.store_overflow,
                                 exp_nb.final_result, got.from_key, got.nearest_key,
                                 got.distance, got.neighbour_valid, got.store_overflow,
                                 got.final_result);
                end
            end
        end
    end

    task automatic add_point(logic [31:0] key, logic [31:0] x, logic [31:0] y,
                             logic last, logic drain_first = 0);
        point_t p;
        p.key = key;
        p.x = x;
        p.y = y;
        p.last = last;
        p.drain_first = drain_first;
        pending_points.push_back(p);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    initial
    begin
        int n_items;
        int set_len;
        int mode;
        logic [31:0] key;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        stored_cnt = 0;
        ovf_seen   = 1'b0;
        mismatches = 0;
        burst_left = 0;
        gap_left   = 0;
        stall_left = 0;

        // single point: no neighbour
        add_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        // opposite corners, then a repeated key that closes the set
        add_point(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        add_point(32'h1, 32'h8000_0000, 32'h8000_0000, 0);
        add_point(32'h0, 32'h1234_5678, 32'h0, 1);
        // coincident points and equidistant ties
        add_point(32'd10, 32'h0, 32'h0, 0);
        add_point(32'd11, 32'h0, 32'h0, 0);
        add_point(32'd12, 32'h0005_0000, 32'h0, 0);
        add_point(32'd13, 32'hFFFB_0000, 32'h0, 0);
        add_point(32'd14, 32'h0, 32'h0005_0000, 0);
        add_point(32'd12, 32'h0, 32'h0, 1);
        // mixed extremes on one axis
        add_point(32'hAAAA_5555, 32'h8000_0000, 32'h0000_0001, 0);
        add_point(32'h5555_AAAA, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        n_items = pending_points.size();

        while (n_items < 270)
        begin
            if (n_items > 120 && overflow_sets == 0 && pending_points.size() < 200
                && n_items < 140)
            begin
                // overfill the store: 66 distinct keys, then a repeat
                for (int i = 0; i < 67; i++)
                    add_point(i == 66 ? 32'h100 : 32'h100 + i, $urandom(), $urandom(),
                              i == 66, i == 0);
                overflow_sets = -1;
                n_items += 67;
                continue;
            end
            set_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < set_len; i++)
            begin
                key = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : $urandom();
                add_point(key, rand_coord(mode), rand_coord(mode), i == set_len - 1,
                          i == 0 && $urandom_range(0, 7) == 0);
            end
            n_items += set_len;
        end
        overflow_sets = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_points.size() == 0);
        @(posedge clk);
        while (s_tvalid)
            @(posedge clk);
        while (expected_neighbours.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);

        $display("Covered %0d items in %0d sets, %0d results, %0d overflowing set(s).",
                 n_items, sets_done, results_seen, overflow_sets);
        $display("Duplicates, ties, zero distances, extremes and single-point sets included.");
        if (mismatches == 0 && expected_neighbours.size() == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_neighbours.size());
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

endmodule
